/* hdl/obb_pkg.sv */
// shared widths, payload types and pipeline control type for the 2d oriented box overlap test
// no dependencies; imported by every module of the block

package obb_pkg;

    localparam int COORD_W    = 20;  // signed q12.8 center
    localparam int DIR_W      = 16;  // signed q1.14 direction
    localparam int SIZE_W     = 20;  // unsigned q12.8 full size
    localparam int DELTA_W    = COORD_W + 1;
    localparam int DPROD_W    = 2 * DIR_W;          // direction times direction
    localparam int DDOT_W     = DPROD_W + 1;        // sum of two of them
    localparam int PPROD_W    = DELTA_W + DIR_W;    // center delta times direction
    localparam int PDOT_W     = PPROD_W + 1;
    localparam int EPROD_W    = SIZE_W + DDOT_W;    // size times |cos| or |sin|
    localparam int OWN_SHIFT  = 28;
    localparam int PROJ_SHIFT = 15;
    localparam int RHS_W      = PDOT_W + PROJ_SHIFT;
    localparam int LHS_W      = EPROD_W + 2;
    localparam int NUM_STAGES = 6;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic        [SIZE_W-1:0]  width;
        logic        [SIZE_W-1:0]  height;
    } box_t;

    // projections after the third stage, all as magnitudes
    typedef struct packed {
        logic [SIZE_W-1:0] aw;
        logic [SIZE_W-1:0] ah;
        logic [SIZE_W-1:0] bw;
        logic [SIZE_W-1:0] bh;
        logic [DDOT_W-1:0] cos_abs;
        logic [DDOT_W-1:0] sin_abs;
        logic [PDOT_W-1:0] proj_ax;
        logic [PDOT_W-1:0] proj_ay;
        logic [PDOT_W-1:0] proj_bx;
        logic [PDOT_W-1:0] proj_by;
    } proj_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } pipe_ctl_t;

endpackage

/* hdl/obb_proj.sv */
// stages 1 to 3: center delta, direction and delta products, dot product magnitudes
// depends on obb_pkg

module obb_proj (
    input  logic               clk,
    input  obb_pkg::pipe_ctl_t ctl,
    input  obb_pkg::box_t      box_a,
    input  obb_pkg::box_t      box_b,
    output obb_pkg::proj_t     proj
);
    import obb_pkg::*;

    // stage 1
    box_t                      a1_reg, b1_reg;
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    logic signed [DELTA_W-1:0] dx_next, dy_next;

    // stage 2
    logic signed [DPROD_W-1:0] xx_reg, yy_reg, yx_reg, xy_reg;
    logic signed [PPROD_W-1:0] dx_ax_reg, dy_ay_reg, dx_ay_reg, dy_ax_reg;
    logic signed [PPROD_W-1:0] dx_bx_reg, dy_by_reg, dx_by_reg, dy_bx_reg;
    logic [SIZE_W-1:0]         aw2_reg, ah2_reg, bw2_reg, bh2_reg;

    // stage 3
    logic signed [DDOT_W-1:0]  cos_next, sin_next;
    logic signed [PDOT_W-1:0]  pax_next, pay_next, pbx_next, pby_next;
    proj_t                     proj_reg, proj_next;

    assign dx_next = {box_b.center_x[COORD_W-1], box_b.center_x}
                   - {box_a.center_x[COORD_W-1], box_a.center_x};
    assign dy_next = {box_b.center_y[COORD_W-1], box_b.center_y}
                   - {box_a.center_y[COORD_W-1], box_a.center_y};

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            a1_reg <= box_a;
            b1_reg <= box_b;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            xx_reg    <= $signed(a1_reg.dir_x) * $signed(b1_reg.dir_x);
            yy_reg    <= $signed(a1_reg.dir_y) * $signed(b1_reg.dir_y);
            yx_reg    <= $signed(a1_reg.dir_y) * $signed(b1_reg.dir_x);
            xy_reg    <= $signed(a1_reg.dir_x) * $signed(b1_reg.dir_y);
            dx_ax_reg <= dx_reg * $signed(a1_reg.dir_x);
            dy_ay_reg <= dy_reg * $signed(a1_reg.dir_y);
            dx_ay_reg <= dx_reg * $signed(a1_reg.dir_y);
            dy_ax_reg <= dy_reg * $signed(a1_reg.dir_x);
            dx_bx_reg <= dx_reg * $signed(b1_reg.dir_x);
            dy_by_reg <= dy_reg * $signed(b1_reg.dir_y);
            dx_by_reg <= dx_reg * $signed(b1_reg.dir_y);
            dy_bx_reg <= dy_reg * $signed(b1_reg.dir_x);
            aw2_reg   <= a1_reg.width;
            ah2_reg   <= a1_reg.height;
            bw2_reg   <= b1_reg.width;
            bh2_reg   <= b1_reg.height;
        end
    end

    // every box-to-box axis term reduces to |cos| or |sin| of the relative angle
    always_comb
    begin
        cos_next = DDOT_W'(xx_reg) + DDOT_W'(yy_reg);
        sin_next = DDOT_W'(yx_reg) - DDOT_W'(xy_reg);
        pax_next = PDOT_W'(dx_ax_reg) + PDOT_W'(dy_ay_reg);
        pay_next = PDOT_W'(dy_ax_reg) - PDOT_W'(dx_ay_reg);
        pbx_next = PDOT_W'(dx_bx_reg) + PDOT_W'(dy_by_reg);
        pby_next = PDOT_W'(dy_bx_reg) - PDOT_W'(dx_by_reg);

        proj_next.aw      = aw2_reg;
        proj_next.ah      = ah2_reg;
        proj_next.bw      = bw2_reg;
        proj_next.bh      = bh2_reg;
        proj_next.cos_abs = cos_next[DDOT_W-1] ? DDOT_W'(-cos_next) : DDOT_W'(cos_next);
        proj_next.sin_abs = sin_next[DDOT_W-1] ? DDOT_W'(-sin_next) : DDOT_W'(sin_next);
        proj_next.proj_ax = pax_next[PDOT_W-1] ? PDOT_W'(-pax_next) : PDOT_W'(pax_next);
        proj_next.proj_ay = pay_next[PDOT_W-1] ? PDOT_W'(-pay_next) : PDOT_W'(pay_next);
        proj_next.proj_bx = pbx_next[PDOT_W-1] ? PDOT_W'(-pbx_next) : PDOT_W'(pbx_next);
        proj_next.proj_by = pby_next[PDOT_W-1] ? PDOT_W'(-pby_next) : PDOT_W'(pby_next);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[2])
        begin
            proj_reg <= proj_next;
        end
    end

    assign proj = proj_reg;

endmodule

/* hdl/obb_cmp.sv */
// stages 4 to 6: extent products, extent sums and the four axis compares
// depends on obb_pkg

module obb_cmp (
    input  logic               clk,
    input  obb_pkg::pipe_ctl_t ctl,
    input  obb_pkg::proj_t     proj,
    output logic               overlap
);
    import obb_pkg::*;

    // stage 4
    logic [EPROD_W-1:0] aw_c_reg, aw_s_reg, ah_c_reg, ah_s_reg;
    logic [EPROD_W-1:0] bw_c_reg, bw_s_reg, bh_c_reg, bh_s_reg;
    logic [SIZE_W-1:0]  aw4_reg, ah4_reg, bw4_reg, bh4_reg;
    logic [PDOT_W-1:0]  pax4_reg, pay4_reg, pbx4_reg, pby4_reg;

    // stage 5
    logic [LHS_W-1:0]   lhs_ax_reg, lhs_ay_reg, lhs_bx_reg, lhs_by_reg;
    logic [LHS_W-1:0]   lhs_ax_next, lhs_ay_next, lhs_bx_next, lhs_by_next;
    logic [PDOT_W-1:0]  pax5_reg, pay5_reg, pbx5_reg, pby5_reg;

    // stage 6
    logic               overlap_reg, overlap_next;
    logic [LHS_W-1:0]   rhs_ax, rhs_ay, rhs_bx, rhs_by;

    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            aw_c_reg <= EPROD_W'(proj.aw) * EPROD_W'(proj.cos_abs);
            aw_s_reg <= EPROD_W'(proj.aw) * EPROD_W'(proj.sin_abs);
            ah_c_reg <= EPROD_W'(proj.ah) * EPROD_W'(proj.cos_abs);
            ah_s_reg <= EPROD_W'(proj.ah) * EPROD_W'(proj.sin_abs);
            bw_c_reg <= EPROD_W'(proj.bw) * EPROD_W'(proj.cos_abs);
            bw_s_reg <= EPROD_W'(proj.bw) * EPROD_W'(proj.sin_abs);
            bh_c_reg <= EPROD_W'(proj.bh) * EPROD_W'(proj.cos_abs);
            bh_s_reg <= EPROD_W'(proj.bh) * EPROD_W'(proj.sin_abs);
            aw4_reg  <= proj.aw;
            ah4_reg  <= proj.ah;
            bw4_reg  <= proj.bw;
            bh4_reg  <= proj.bh;
            pax4_reg <= proj.proj_ax;
            pay4_reg <= proj.proj_ay;
            pbx4_reg <= proj.proj_bx;
            pby4_reg <= proj.proj_by;
        end
    end

    // own half extent plus the other box's projected half extents, all at q12.8 * 2^29
    always_comb
    begin
        lhs_ax_next = LHS_W'({aw4_reg, {OWN_SHIFT{1'b0}}}) + LHS_W'(bw_c_reg)
                    + LHS_W'(bh_s_reg);
        lhs_ay_next = LHS_W'({ah4_reg, {OWN_SHIFT{1'b0}}}) + LHS_W'(bw_s_reg)
                    + LHS_W'(bh_c_reg);
        lhs_bx_next = LHS_W'({bw4_reg, {OWN_SHIFT{1'b0}}}) + LHS_W'(aw_c_reg)
                    + LHS_W'(ah_s_reg);
        lhs_by_next = LHS_W'({bh4_reg, {OWN_SHIFT{1'b0}}}) + LHS_W'(aw_s_reg)
                    + LHS_W'(ah_c_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[4])
        begin
            lhs_ax_reg <= lhs_ax_next;
            lhs_ay_reg <= lhs_ay_next;
            lhs_bx_reg <= lhs_bx_next;
            lhs_by_reg <= lhs_by_next;
            pax5_reg   <= pax4_reg;
            pay5_reg   <= pay4_reg;
            pbx5_reg   <= pbx4_reg;
            pby5_reg   <= pby4_reg;
        end
    end

    // touching is not separation
    always_comb
    begin
        rhs_ax       = LHS_W'({pax5_reg, {PROJ_SHIFT{1'b0}}});
        rhs_ay       = LHS_W'({pay5_reg, {PROJ_SHIFT{1'b0}}});
        rhs_bx       = LHS_W'({pbx5_reg, {PROJ_SHIFT{1'b0}}});
        rhs_by       = LHS_W'({pby5_reg, {PROJ_SHIFT{1'b0}}});
        overlap_next = !((lhs_ax_reg < rhs_ax) || (lhs_ay_reg < rhs_ay)
                      || (lhs_bx_reg < rhs_bx) || (lhs_by_reg < rhs_by));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[5])
        begin
            overlap_reg <= overlap_next;
        end
    end

    assign overlap = overlap_reg;

endmodule

/* hdl/obb_overlap_test_2d_top.sv */
// top level of the 2d oriented box overlap test: ports, stage valids and stall control
// depends on obb_pkg, obb_proj and obb_cmp
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | a_* and b_* center, direction, width, height
//   out     | out_valid / out_ready| overlap
//
// six register stages, one request per cycle while the output does not stall; out_valid
// is the valid bit of the last stage. each stage loads when it is empty or the stage
// after it moves, so bubbles are squeezed out while the output is stalled. reset clears
// only the stage valid bits; out_valid holds with overlap unchanged until it is taken.

module obb_overlap_test_2d_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [obb_pkg::COORD_W-1:0]   a_center_x,
    input  logic signed [obb_pkg::COORD_W-1:0]   a_center_y,
    input  logic signed [obb_pkg::DIR_W-1:0]     a_dir_x,
    input  logic signed [obb_pkg::DIR_W-1:0]     a_dir_y,
    input  logic        [obb_pkg::SIZE_W-1:0]    a_width,
    input  logic        [obb_pkg::SIZE_W-1:0]    a_height,
    input  logic signed [obb_pkg::COORD_W-1:0]   b_center_x,
    input  logic signed [obb_pkg::COORD_W-1:0]   b_center_y,
    input  logic signed [obb_pkg::DIR_W-1:0]     b_dir_x,
    input  logic signed [obb_pkg::DIR_W-1:0]     b_dir_y,
    input  logic        [obb_pkg::SIZE_W-1:0]    b_width,
    input  logic        [obb_pkg::SIZE_W-1:0]    b_height,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 overlap
);
    import obb_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    pipe_ctl_t             ctl;
    box_t                  box_a, box_b;
    proj_t                 proj;

    assign box_a.center_x = a_center_x;
    assign box_a.center_y = a_center_y;
    assign box_a.dir_x    = a_dir_x;
    assign box_a.dir_y    = a_dir_y;
    assign box_a.width    = a_width;
    assign box_a.height   = a_height;
    assign box_b.center_x = b_center_x;
    assign box_b.center_y = b_center_y;
    assign box_b.dir_x    = b_dir_x;
    assign box_b.dir_y    = b_dir_y;
    assign box_b.width    = b_width;
    assign box_b.height   = b_height;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        ctl.en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            ctl.en[i] = !valid_reg[i] || ctl.en[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (ctl.en[i])
            begin
                valid_next[i] = (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = ctl.en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    obb_proj u_proj (
        .clk   (clk),
        .ctl   (ctl),
        .box_a (box_a),
        .box_b (box_b),
        .proj  (proj)
    );

    obb_cmp u_cmp (
        .clk     (clk),
        .ctl     (ctl),
        .proj    (proj),
        .overlap (overlap)
    );

endmodule

/* sim/tb_obb_overlap_test_2d_top.sv */
// testbench for obb_overlap_test_2d_top: directed and random box pairs with random idling on
// both channels. an internal separating-axis predictor computes the expected overlap results.
// depends on obb_pkg and the rtl of the block only

module tb_obb_overlap_test_2d_top;

    import obb_pkg::*;

    localparam real PI_VAL      = 3.14159265358979;
    localparam int  MAX_PRINTS  = 30;
    localparam int  DIR_ONE     = 16384;   // 1.0 in q1.14

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic out_valid;
    logic out_ready;
    logic overlap;

    box_t box_a;
    box_t box_b;

    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_left;
    int   error_count;
    logic overlap_expected_q[$];

    obb_overlap_test_2d_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .a_center_x (box_a.center_x),
        .a_center_y (box_a.center_y),
        .a_dir_x    (box_a.dir_x),
        .a_dir_y    (box_a.dir_y),
        .a_width    (box_a.width),
        .a_height   (box_a.height),
        .b_center_x (box_b.center_x),
        .b_center_y (box_b.center_y),
        .b_dir_x    (box_b.dir_x),
        .b_dir_y    (box_b.dir_y),
        .b_width    (box_b.width),
        .b_height   (box_b.height),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .overlap    (overlap)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    // true when axis u separates; all terms at q12.8 * 2^29 so the compare is exact
    function automatic bit axis_separates(longint dx, longint dy, longint ux, longint uy,
                                          longint own_size,
                                          longint oxx, longint oxy, longint oyx, longint oyy,
                                          longint other_w, longint other_h);
        longint cos_t;
        longint sin_t;
        longint gap;
        longint reach;
        longint span;
        cos_t = oxx * ux + oxy * uy;
        sin_t = oyx * ux + oyy * uy;
        gap   = dx * ux + dy * uy;
        if (cos_t < 0)
            cos_t = -cos_t;
        if (sin_t < 0)
            sin_t = -sin_t;
        if (gap < 0)
            gap = -gap;
        reach = own_size * (64'sd1 <<< 28) + other_w * cos_t + other_h * sin_t;
        span  = gap * (64'sd1 <<< 15);
        return reach < span;
    endfunction

    function automatic logic predict_overlap(box_t a, box_t b);
        longint axx;
        longint axy;
        longint bxx;
        longint bxy;
        longint aw;
        longint ah;
        longint bw;
        longint bh;
        longint dx;
        longint dy;
        bit     sep;
        axx = $signed(a.dir_x);
        axy = $signed(a.dir_y);
        bxx = $signed(b.dir_x);
        bxy = $signed(b.dir_y);
        aw  = {44'd0, a.width};
        ah  = {44'd0, a.height};
        bw  = {44'd0, b.width};
        bh  = {44'd0, b.height};
        dx  = longint'($signed(b.center_x)) - longint'($signed(a.center_x));
        dy  = longint'($signed(b.center_y)) - longint'($signed(a.center_y));
        // local y axis is the perpendicular (-dir_y, dir_x)
        sep = axis_separates(dx, dy, axx, axy, aw, bxx, bxy, -bxy, bxx, bw, bh)
           || axis_separates(dx, dy, -axy, axx, ah, bxx, bxy, -bxy, bxx, bw, bh)
           || axis_separates(dx, dy, bxx, bxy, bw, axx, axy, -axy, axx, aw, ah)
           || axis_separates(dx, dy, -bxy, bxx, bh, axx, axy, -axy, axx, aw, ah);
        return sep ? 1'b0 : 1'b1;
    endfunction

    // ---------------------------------------------------------------- helpers

    task automatic report_mismatch(string msg);
        if (error_count < MAX_PRINTS)
            $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic box_t make_box(int cx, int cy, int dx, int dy, int w, int h);
        box_t b;
        b.center_x = cx[COORD_W-1:0];
        b.center_y = cy[COORD_W-1:0];
        b.dir_x    = dx[DIR_W-1:0];
        b.dir_y    = dy[DIR_W-1:0];
        b.width    = w[SIZE_W-1:0];
        b.height   = h[SIZE_W-1:0];
        return b;
    endfunction

    function automatic int clamp_coord(int v);
        if (v > 524287)
            return 524287;
        if (v < -524288)
            return -524288;
        return v;
    endfunction

    function automatic int rand_size();
        int sh;
        sh = $urandom_range(19, 2);
        return $urandom_range(1 << sh, 0);
    endfunction

    function automatic box_t rand_box_bits();
        logic [127:0] r;
        r = {$urandom(), $urandom(), $urandom(), $urandom()};
        return r[$bits(box_t)-1:0];
    endfunction

    // drive one request and hold it until the block takes it
    task automatic send_box_pair(box_t a, box_t b);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        box_a    <= a;
        box_b    <= b;
        do
            @(posedge clk);
        while (!in_ready);
        overlap_expected_q.push_back(predict_overlap(a, b));
    endtask

    // well-formed pairs with unit directions placed near each other, plus axis-aligned pairs
    // at or one lsb from edge contact, and raw noise
    task automatic send_random_pair();
        box_t a;
        box_t b;
        int   kind;
        int   cx;
        int   cy;
        int   reach;
        int   aw;
        int   bw;
        real  ang;
        kind = $urandom_range(99, 0);
        if (kind < 15)
        begin
            a = rand_box_bits();
            b = rand_box_bits();
        end
        else if (kind < 30)
        begin
            aw = 2 * $urandom_range(4000, 0);
            bw = 2 * $urandom_range(4000, 0);
            cx = $urandom_range(400000, 0) - 200000;
            cy = $urandom_range(400000, 0) - 200000;
            a  = make_box(cx, cy, DIR_ONE, 0, aw, rand_size());
            b  = make_box(cx + (aw + bw) / 2 + $urandom_range(2, 0) - 1, cy, DIR_ONE, 0,
                          bw, rand_size());
        end
        else
        begin
            cx = $urandom_range(400000, 0) - 200000;
            cy = $urandom_range(400000, 0) - 200000;
            ang = $urandom_range(3599, 0) * PI_VAL / 1800.0;
            a = make_box(cx, cy, int'(DIR_ONE * $cos(ang)), int'(DIR_ONE * $sin(ang)),
                         rand_size(), rand_size());
            reach = (a.width + a.height) * 3 / 4 + 1;
            ang = $urandom_range(3599, 0) * PI_VAL / 1800.0;
            b = make_box(0, 0, int'(DIR_ONE * $cos(ang)), int'(DIR_ONE * $sin(ang)),
                         rand_size(), rand_size());
            reach = reach + (b.width + b.height) * 3 / 4;
            b.center_x = 20'(clamp_coord(cx + $urandom_range(2 * reach, 0) - reach));
            b.center_y = 20'(clamp_coord(cy + $urandom_range(2 * reach, 0) - reach));
        end
        send_box_pair(a, b);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // identical squares, edge contact on x and y, one step past contact
        send_box_pair(make_box(0, 0, DIR_ONE, 0, 512, 512), make_box(0, 0, DIR_ONE, 0, 512, 512));
        send_box_pair(make_box(0, 0, DIR_ONE, 0, 512, 512), make_box(512, 0, DIR_ONE, 0, 512, 512));
        send_box_pair(make_box(0, 0, DIR_ONE, 0, 512, 512), make_box(513, 0, DIR_ONE, 0, 512, 512));
        send_box_pair(make_box(0, 0, DIR_ONE, 0, 512, 512), make_box(0, 512, DIR_ONE, 0, 512, 512));
        send_box_pair(make_box(0, 0, DIR_ONE, 0, 512, 512), make_box(0, -513, DIR_ONE, 0, 512, 512));
        // rotated box near a corner, apart and overlapping
        send_box_pair(make_box(0, 0, DIR_ONE, 0, 512, 512), make_box(700, 0, 11585, 11585, 512, 512));
        send_box_pair(make_box(0, 0, DIR_ONE, 0, 512, 512), make_box(600, 0, 11585, 11585, 512, 512));
        send_box_pair(make_box(0, 0, 0, DIR_ONE, 2048, 256), make_box(300, 300, -DIR_ONE, 0, 256, 2048));
        // zero direction on one box, then on both
        send_box_pair(make_box(0, 0, 0, 0, 512, 512), make_box(5000, 0, DIR_ONE, 0, 512, 512));
        send_box_pair(make_box(0, 0, 0, 0, 512, 512), make_box(5000, 9000, 0, 0, 512, 512));
        // directions that are not unit length, including the most negative code
        send_box_pair(make_box(0, 0, -32768, 0, 512, 512), make_box(900, 0, 0, -32768, 512, 512));
        send_box_pair(make_box(10, -10, 32767, -32768, 300, 700), make_box(-400, 400, -32768, 32767, 900, 100));
        send_box_pair(make_box(0, 0, DIR_ONE, DIR_ONE, 512, 512), make_box(800, 800, -DIR_ONE, -DIR_ONE, 512, 512));
        // extreme centers and sizes
        send_box_pair(make_box(-524288, -524288, DIR_ONE, 0, 0, 0), make_box(524287, 524287, DIR_ONE, 0, 0, 0));
        send_box_pair(make_box(-524288, -524288, DIR_ONE, 0, 1048575, 1048575),
                      make_box(524287, 524287, DIR_ONE, 0, 1048575, 1048575));
        send_box_pair(make_box(-524288, 524287, -DIR_ONE, DIR_ONE, 1048575, 1048575),
                      make_box(524287, -524288, 32767, -32768, 1048575, 1048575));
        send_box_pair(make_box(-524288, 0, 11585, -11585, 1048575, 0),
                      make_box(524287, 0, -32768, -32768, 0, 1048575));
        // zero-size boxes at one point and one lsb apart
        send_box_pair(make_box(77, -33, DIR_ONE, 0, 0, 0), make_box(77, -33, 0, DIR_ONE, 0, 0));
        send_box_pair(make_box(77, -33, DIR_ONE, 0, 0, 0), make_box(78, -33, 0, DIR_ONE, 0, 0));
    endtask

    task automatic test_random_stream(int count, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
            send_random_pair();
    endtask

    // receiver stops for a long stretch while requests keep coming, so the pipe fills
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 80;
        repeat (30)
            send_random_pair();
    endtask

    // ---------------------------------------------------------------- result check

    always @(posedge clk)
    begin : result_check
        logic want;
        if (out_valid && out_ready)
        begin
            if (overlap_expected_q.size() == 0)
            begin
                report_mismatch($sformatf("overlap=%0b with no request pending", overlap));
            end
            else
            begin
                want = overlap_expected_q.pop_front();
                if (overlap !== want)
                    report_mismatch($sformatf("overlap=%0b, expected %0b", overlap, want));
            end
        end
        if (hold_left > 0)
        begin
            hold_left  = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_ready     = 1'b0;
        box_a         = '0;
        box_b         = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        error_count   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_stream(300, 16, 47);
        test_random_stream(300, 47, 16);
        test_output_stall();
        test_random_stream(300, 0, 0);
        in_valid <= 1'b0;

        while (overlap_expected_q.size() != 0)
            @(posedge clk);
        repeat (NUM_STAGES * 2) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
